### src/oblag_pkg.sv
// Shared types, codes and constants of the order book level aggregator.
package oblag_pkg;

    localparam int DEF_MAX_ORDERS = 1024;
    localparam int DEF_MAX_LEVELS = 16;

    localparam int ID_W       = 64;
    localparam int PRICE_W    = 32;
    localparam int QTY_W      = 32;
    localparam int TOT_W      = 42;
    localparam int DEPTH_W    = 5;
    localparam int LIVE_OUT_W = 11;
    localparam int LVL_OUT_W  = 5;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_AMEND  = 2'd2,
        OP_SNAP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_ORD_FULL  = 3'd3,
        ST_LVL_FULL  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ROUTE, S_SCAN, S_SCAN_END, S_DECIDE, S_LK_OLD, S_LK_CHK,
        S_CHK, S_REM, S_LK_NEW, S_ADD, S_SAME, S_WSLOT, S_SNAP, S_RESULT
    } t_state;

    typedef struct packed {
        logic               vld;
        logic [ID_W-1:0]    id;
        logic               buy;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic    load;
        logic    clear_step;
        logic    scan_step;
        logic    lk_old;
        logic    lk_new;
        logic    lv_rem;
        logic    lv_add;
        logic    lv_same;
        logic    wslot;
        logic    snap_init;
        logic    snap_emit;
        logic    res_emit;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic free_found;
        t_op  op;
        logic price_same;
        logic new_hit;
        logic side_full;
        logic frees;
        logic snap_empty;
        logic snap_last;
        logic out_free;
    } t_sts;

endpackage

### src/order_book_level_aggregator_unit.sv
// Add, cancel and amend scan the slot memory for the id, one slot read per cycle, then
// update the level tables and register their result. A snapshot registers its levels
// one after another as the output frees. One item at a time: the next item is accepted
// in the cycle after the last result is registered, even while that result waits.
// Reset is synchronous: a clearing pass over every slot empties the slot memory,
// and no item is accepted until it ends.
module order_book_level_aggregator_unit import oblag_pkg::*; #(
    parameter int MAX_ORDERS = DEF_MAX_ORDERS,
    parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_operation,
    input  logic [ID_W-1:0]       i_order_id,
    input  logic                  i_is_buy,
    input  logic [PRICE_W-1:0]    i_price,
    input  logic [QTY_W-1:0]      i_quantity,
    input  logic [DEPTH_W-1:0]    i_snapshot_depth,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_status,
    output logic [LIVE_OUT_W-1:0] o_live_orders,
    output logic [LVL_OUT_W-1:0]  o_bid_levels,
    output logic [LVL_OUT_W-1:0]  o_ask_levels,
    output logic                  o_level_valid,
    output logic                  o_level_side,
    output logic [PRICE_W-1:0]    o_level_price,
    output logic [TOT_W-1:0]      o_level_quantity,
    output logic                  o_last
);
    t_cmd cmd;
    t_sts sts;

    oblag_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    oblag_dp #(.MAX_ORDERS(MAX_ORDERS), .MAX_LEVELS(MAX_LEVELS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_operation      (i_operation),
        .i_order_id       (i_order_id),
        .i_is_buy         (i_is_buy),
        .i_price          (i_price),
        .i_quantity       (i_quantity),
        .i_snapshot_depth (i_snapshot_depth),
        .i_ready          (i_ready),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_live_orders    (o_live_orders),
        .o_bid_levels     (o_bid_levels),
        .o_ask_levels     (o_ask_levels),
        .o_level_valid    (o_level_valid),
        .o_level_side     (o_level_side),
        .o_level_price    (o_level_price),
        .o_level_quantity (o_level_quantity),
        .o_last           (o_last)
    );

`ifndef ASSERT_OFF
    a_add_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.lv_add |-> (sts.new_hit || !sts.side_full))
        else $error("level insert into a full table");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.res_emit || cmd.snap_emit) |-> sts.out_free)
        else $error("result overwrites a pending result");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_bid_levels) <= MAX_LEVELS && 32'(o_ask_levels) <= MAX_LEVELS))
        else $error("level count beyond table size");
`endif
endmodule

### src/oblag_ram.sv
// Generic single write port, single read port RAM with registered read.
module oblag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/oblag_ctrl.sv
// Controller state machine of the order book level aggregator.
module oblag_ctrl import oblag_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);
    t_state  r_state, n_state;
    t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.scan_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_ROUTE;
            end
            S_ROUTE: begin
                n_status = ST_OK;
                if (i_sts.op == OP_SNAP) begin
                    n_state = i_sts.snap_empty ? S_RESULT : S_SNAP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) n_state = S_SCAN_END;
            end
            S_SCAN_END: n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_sts.op == OP_ADD) begin
                    if (i_sts.found) begin
                        n_status = ST_DUP;
                        n_state  = S_RESULT;
                    end else if (!i_sts.free_found) begin
                        n_status = ST_ORD_FULL;
                        n_state  = S_RESULT;
                    end else begin
                        n_state = S_LK_NEW;
                    end
                end else if (!i_sts.found) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_LK_OLD;
                end
            end
            S_LK_OLD: begin
                if (i_sts.op == OP_CANCEL) n_state = S_REM;
                else if (i_sts.price_same) n_state = S_SAME;
                else n_state = S_LK_CHK;
            end
            S_LK_CHK: n_state = S_CHK;
            S_CHK: begin
                if (!i_sts.new_hit && i_sts.side_full && !i_sts.frees) begin
                    n_status = ST_LVL_FULL;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_REM;
                end
            end
            S_REM: n_state = (i_sts.op == OP_CANCEL) ? S_WSLOT : S_LK_NEW;
            S_LK_NEW: n_state = S_ADD;
            S_ADD: begin
                if (!i_sts.new_hit && i_sts.side_full) begin
                    n_status = ST_LVL_FULL;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_WSLOT;
                end
            end
            S_SAME: n_state = S_WSLOT;
            S_WSLOT: n_state = S_RESULT;
            S_SNAP: begin
                if (i_sts.out_free && i_sts.snap_last) n_state = S_IDLE;
            end
            S_RESULT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = r_status;
        o_ready      = 1'b0;
        unique case (r_state)
            S_CLEAR:  o_cmd.clear_step = 1'b1;
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_ROUTE:  o_cmd.snap_init = (i_sts.op == OP_SNAP);
            S_SCAN:   o_cmd.scan_step = 1'b1;
            S_LK_OLD: o_cmd.lk_old = 1'b1;
            S_LK_CHK: o_cmd.lk_new = 1'b1;
            S_LK_NEW: o_cmd.lk_new = 1'b1;
            S_REM:    o_cmd.lv_rem = 1'b1;
            S_ADD:    o_cmd.lv_add = i_sts.new_hit || !i_sts.side_full;
            S_SAME:   o_cmd.lv_same = 1'b1;
            S_WSLOT:  o_cmd.wslot = 1'b1;
            S_SNAP:   o_cmd.snap_emit = i_sts.out_free;
            S_RESULT: o_cmd.res_emit = i_sts.out_free;
            default:  o_cmd.status = r_status;
        endcase
    end
endmodule

### src/oblag_dp.sv
// Datapath: order slot memory, sorted level tables, snapshot walk, result register.
module oblag_dp import oblag_pkg::*; #(
    parameter int MAX_ORDERS = DEF_MAX_ORDERS,
    parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_operation,
    input  logic [ID_W-1:0]       i_order_id,
    input  logic                  i_is_buy,
    input  logic [PRICE_W-1:0]    i_price,
    input  logic [QTY_W-1:0]      i_quantity,
    input  logic [DEPTH_W-1:0]    i_snapshot_depth,
    input  logic                  i_ready,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_valid,
    output logic [2:0]            o_status,
    output logic [LIVE_OUT_W-1:0] o_live_orders,
    output logic [LVL_OUT_W-1:0]  o_bid_levels,
    output logic [LVL_OUT_W-1:0]  o_ask_levels,
    output logic                  o_level_valid,
    output logic                  o_level_side,
    output logic [PRICE_W-1:0]    o_level_price,
    output logic [TOT_W-1:0]      o_level_quantity,
    output logic                  o_last
);
    localparam int AW  = $clog2(MAX_ORDERS);
    localparam int CW  = $clog2(MAX_ORDERS + 1);
    localparam int LW  = $clog2(MAX_LEVELS + 1);
    localparam int LIW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    t_op                r_op;
    logic [ID_W-1:0]    r_id;
    logic               r_buy;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;
    logic [DEPTH_W-1:0] r_depth;

    logic [AW-1:0]      r_scan_addr, r_chk_addr;
    logic               r_chk_vld;
    logic               r_found, r_free_found;
    logic [AW-1:0]      r_f_addr, r_free_addr;
    logic               r_f_buy;
    logic [PRICE_W-1:0] r_f_price;
    logic [QTY_W-1:0]   r_f_qty;

    logic [PRICE_W-1:0] r_lp [2][MAX_LEVELS];
    logic [TOT_W-1:0]   r_lt [2][MAX_LEVELS];
    logic [CW-1:0]      r_lm [2][MAX_LEVELS];
    logic [LW-1:0]      r_used [2];
    logic [PRICE_W-1:0] n_lp [2][MAX_LEVELS];
    logic [TOT_W-1:0]   n_lt [2][MAX_LEVELS];
    logic [CW-1:0]      n_lm [2][MAX_LEVELS];
    logic [LW-1:0]      n_used [2];
    logic [CW-1:0]      r_live;

    logic               r_old_hit, r_frees, r_new_hit;
    logic [LIW-1:0]     r_old_idx, r_new_idx;

    logic [LW-1:0]      r_nb, r_na, nb_c, na_c;
    logic               r_snap_side;
    logic [LIW-1:0]     r_lvl_idx;
    logic               snap_last;

    logic               r_out_valid;
    t_status            r_o_status;
    logic [LIVE_OUT_W-1:0] r_o_live;
    logic [LVL_OUT_W-1:0]  r_o_bid, r_o_ask;
    logic               r_o_lvalid, r_o_side, r_o_last;
    logic [PRICE_W-1:0] r_o_price;
    logic [TOT_W-1:0]   r_o_qty;
    logic               out_free;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_slot              ram_wdata, ram_rdata;
    logic [SLOT_W-1:0]  ram_rbits;

    logic               sd;
    logic [PRICE_W-1:0] key;
    logic               lk_hit;
    logic [LIW-1:0]     lk_idx, lk_pos;
    logic [CW-1:0]      lk_mem;

    logic               rd_side;
    logic [LIW-1:0]     rd_idx;
    logic [PRICE_W-1:0] rp;
    logic [TOT_W-1:0]   rt;
    logic [CW-1:0]      rm, mnew;

    oblag_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ORDERS)) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan_addr),
        .o_rdata (ram_rbits)
    );
    assign ram_rdata = t_slot'(ram_rbits);

    assign sd  = (r_op == OP_ADD) ? ~r_buy : ~r_f_buy;
    assign key = i_cmd.lk_old ? r_f_price : r_price;

    always_comb begin
        ram_we    = i_cmd.clear_step || i_cmd.wslot;
        ram_waddr = r_scan_addr;
        ram_wdata = '0;
        if (i_cmd.wslot) begin
            ram_waddr       = (r_op == OP_ADD) ? r_free_addr : r_f_addr;
            ram_wdata.vld   = (r_op != OP_CANCEL);
            ram_wdata.id    = r_id;
            ram_wdata.buy   = (r_op == OP_ADD) ? r_buy : r_f_buy;
            ram_wdata.price = r_price;
            ram_wdata.qty   = r_qty;
        end
    end

    always_comb begin
        lk_hit = 1'b0;
        lk_idx = '0;
        lk_mem = '0;
        lk_pos = LIW'(r_used[sd]);
        for (int j = MAX_LEVELS - 1; j >= 0; j--) begin
            if (LW'(j) < r_used[sd]) begin
                if (r_lp[sd][j] == key) begin
                    lk_hit = 1'b1;
                    lk_idx = LIW'(j);
                    lk_mem = r_lm[sd][j];
                end
                if ((sd == SIDE_BID) ? (key > r_lp[sd][j]) : (key < r_lp[sd][j])) begin
                    lk_pos = LIW'(j);
                end
            end
        end
    end

    always_comb begin
        if (i_cmd.snap_emit) begin
            rd_side = r_snap_side;
            rd_idx  = r_lvl_idx;
        end else if (i_cmd.lv_add) begin
            rd_side = sd;
            rd_idx  = r_new_idx;
        end else begin
            rd_side = sd;
            rd_idx  = r_old_idx;
        end
    end
    assign rp   = r_lp[rd_side][rd_idx];
    assign rt   = r_lt[rd_side][rd_idx];
    assign rm   = r_lm[rd_side][rd_idx];
    assign mnew = (rm != '0) ? rm - CW'(1) : '0;

    always_comb begin
        n_lp   = r_lp;
        n_lt   = r_lt;
        n_lm   = r_lm;
        n_used = r_used;
        if (i_cmd.lv_rem && r_old_hit) begin
            if (mnew == '0) begin
                for (int j = 0; j < MAX_LEVELS - 1; j++) begin
                    if (LIW'(j) >= r_old_idx) begin
                        n_lp[sd][j] = r_lp[sd][j+1];
                        n_lt[sd][j] = r_lt[sd][j+1];
                        n_lm[sd][j] = r_lm[sd][j+1];
                    end
                end
                n_used[sd] = r_used[sd] - LW'(1);
            end else begin
                n_lt[sd][r_old_idx] = rt - TOT_W'(r_f_qty);
                n_lm[sd][r_old_idx] = mnew;
            end
        end else if (i_cmd.lv_add) begin
            if (r_new_hit) begin
                n_lt[sd][r_new_idx] = rt + TOT_W'(r_qty);
                n_lm[sd][r_new_idx] = rm + CW'(1);
            end else begin
                for (int j = 1; j < MAX_LEVELS; j++) begin
                    if (LIW'(j) > r_new_idx) begin
                        n_lp[sd][j] = r_lp[sd][j-1];
                        n_lt[sd][j] = r_lt[sd][j-1];
                        n_lm[sd][j] = r_lm[sd][j-1];
                    end
                end
                n_lp[sd][r_new_idx] = r_price;
                n_lt[sd][r_new_idx] = TOT_W'(r_qty);
                n_lm[sd][r_new_idx] = CW'(1);
                n_used[sd] = r_used[sd] + LW'(1);
            end
        end else if (i_cmd.lv_same && r_old_hit) begin
            n_lt[sd][r_old_idx] = rt + TOT_W'(r_qty) - TOT_W'(r_f_qty);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lp <= n_lp;
        r_lt <= n_lt;
        r_lm <= n_lm;
    end

    always_comb begin
        nb_c = (32'(r_depth) < 32'(r_used[SIDE_BID])) ? LW'(r_depth) : r_used[SIDE_BID];
        na_c = (32'(r_depth) < 32'(r_used[SIDE_ASK])) ? LW'(r_depth) : r_used[SIDE_ASK];
    end

    assign snap_last = (r_snap_side == SIDE_ASK)
                     ? (LW'(r_lvl_idx) + LW'(1) == r_na)
                     : ((LW'(r_lvl_idx) + LW'(1) == r_nb) && (r_na == '0));
    assign out_free  = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_operation);
            r_id    <= i_order_id;
            r_buy   <= i_is_buy;
            r_price <= i_price;
            r_qty   <= i_quantity;
            r_depth <= i_snapshot_depth;
        end
        if (r_chk_vld && ram_rdata.vld && ram_rdata.id == r_id && !r_found) begin
            r_f_addr  <= r_chk_addr;
            r_f_buy   <= ram_rdata.buy;
            r_f_price <= ram_rdata.price;
            r_f_qty   <= ram_rdata.qty;
        end
        if (r_chk_vld && !ram_rdata.vld && !r_free_found) begin
            r_free_addr <= r_chk_addr;
        end
        if (i_cmd.scan_step) r_chk_addr <= r_scan_addr;
        if (i_cmd.lk_old) begin
            r_old_hit <= lk_hit;
            r_old_idx <= lk_idx;
            r_frees   <= lk_hit && (lk_mem <= CW'(1));
        end
        if (i_cmd.lk_new) begin
            r_new_hit <= lk_hit;
            r_new_idx <= lk_hit ? lk_idx : lk_pos;
        end
        if (i_cmd.snap_init) begin
            r_nb        <= nb_c;
            r_na        <= na_c;
            r_snap_side <= (nb_c == '0) ? SIDE_ASK : SIDE_BID;
            r_lvl_idx   <= '0;
        end else if (i_cmd.snap_emit) begin
            if (r_snap_side == SIDE_BID && LW'(r_lvl_idx) + LW'(1) == r_nb) begin
                r_snap_side <= SIDE_ASK;
                r_lvl_idx   <= '0;
            end else begin
                r_lvl_idx <= r_lvl_idx + LIW'(1);
            end
        end
        if (i_cmd.res_emit || i_cmd.snap_emit) begin
            r_o_live <= LIVE_OUT_W'(r_live);
            r_o_bid  <= LVL_OUT_W'(r_used[SIDE_BID]);
            r_o_ask  <= LVL_OUT_W'(r_used[SIDE_ASK]);
        end
        if (i_cmd.res_emit) begin
            r_o_status <= i_cmd.status;
            r_o_lvalid <= 1'b0;
            r_o_side   <= 1'b0;
            r_o_price  <= '0;
            r_o_qty    <= '0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.snap_emit) begin
            r_o_status <= ST_OK;
            r_o_lvalid <= 1'b1;
            r_o_side   <= r_snap_side;
            r_o_price  <= rp;
            r_o_qty    <= rt;
            r_o_last   <= snap_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr  <= '0;
            r_chk_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_used[0]    <= '0;
            r_used[1]    <= '0;
            r_live       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_used    <= n_used;
            r_chk_vld <= i_cmd.scan_step;
            if (i_cmd.load) begin
                r_scan_addr  <= '0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (i_cmd.scan_step || i_cmd.clear_step) begin
                    r_scan_addr <= (r_scan_addr == AW'(MAX_ORDERS - 1)) ? '0
                                 : r_scan_addr + AW'(1);
                end
                if (r_chk_vld && ram_rdata.vld && ram_rdata.id == r_id) r_found <= 1'b1;
                if (r_chk_vld && !ram_rdata.vld) r_free_found <= 1'b1;
            end
            if (i_cmd.wslot) begin
                if (r_op == OP_ADD) begin
                    r_live <= r_live + CW'(1);
                end else if (r_op == OP_CANCEL && r_live != '0) begin
                    r_live <= r_live - CW'(1);
                end
            end
            if (i_cmd.res_emit || i_cmd.snap_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.scan_last  = (r_scan_addr == AW'(MAX_ORDERS - 1));
        o_sts.found      = r_found;
        o_sts.free_found = r_free_found;
        o_sts.op         = r_op;
        o_sts.price_same = (r_price == r_f_price);
        o_sts.new_hit    = r_new_hit;
        o_sts.side_full  = (r_used[sd] == LW'(MAX_LEVELS));
        o_sts.frees      = r_frees;
        o_sts.snap_empty = (nb_c == '0) && (na_c == '0);
        o_sts.snap_last  = snap_last;
        o_sts.out_free   = out_free;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_o_status;
    assign o_live_orders    = r_o_live;
    assign o_bid_levels     = r_o_bid;
    assign o_ask_levels     = r_o_ask;
    assign o_level_valid    = r_o_lvalid;
    assign o_level_side     = r_o_side;
    assign o_level_price    = r_o_price;
    assign o_level_quantity = r_o_qty;
    assign o_last           = r_o_last;
endmodule

### sim/order_book_level_aggregator_unit_tb.sv
// Testbench for the order book level aggregator: shadow book, random traffic, result checks.
module order_book_level_aggregator_unit_tb;
    import oblag_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOOK_ORDERS = DEF_MAX_ORDERS;
    localparam int BOOK_LEVELS = DEF_MAX_LEVELS;

    typedef struct packed {
        logic [2:0]            status;
        logic [LIVE_OUT_W-1:0] live;
        logic [LVL_OUT_W-1:0]  nbid;
        logic [LVL_OUT_W-1:0]  nask;
        logic                  lvalid;
        logic                  lside;
        logic [PRICE_W-1:0]    lprice;
        logic [TOT_W-1:0]      lqty;
        logic                  last;
    } t_book_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [1:0]            i_operation;
    logic [ID_W-1:0]       i_order_id;
    logic                  i_is_buy;
    logic [PRICE_W-1:0]    i_price;
    logic [QTY_W-1:0]      i_quantity;
    logic [DEPTH_W-1:0]    i_snapshot_depth;
    logic                  o_valid;
    logic                  i_ready;
    logic [2:0]            o_status;
    logic [LIVE_OUT_W-1:0] o_live_orders;
    logic [LVL_OUT_W-1:0]  o_bid_levels;
    logic [LVL_OUT_W-1:0]  o_ask_levels;
    logic                  o_level_valid;
    logic                  o_level_side;
    logic [PRICE_W-1:0]    o_level_price;
    logic [TOT_W-1:0]      o_level_quantity;
    logic                  o_last;

    order_book_level_aggregator_unit uut (.*);

    always #1 i_clk = ~i_clk;

    // shadow book: orders by id, levels indexed [is_buy][rank]
    logic [PRICE_W-1:0] ord_price [logic [ID_W-1:0]];
    logic [QTY_W-1:0]   ord_qty   [logic [ID_W-1:0]];
    logic               ord_buy   [logic [ID_W-1:0]];
    logic [ID_W-1:0]    live_ids[$];
    logic [PRICE_W-1:0] lvl_price [2][BOOK_LEVELS];
    logic [TOT_W-1:0]   lvl_total [2][BOOK_LEVELS];
    int                 lvl_count [2][BOOK_LEVELS];
    int                 lvl_used  [2];

    t_book_res expected_results[$];
    int errs = 0;
    int items_sent = 0;
    int results_seen = 0;
    int hold_cycles = 0;
    bit calm = 1'b0;

    function automatic int level_find(bit b, logic [PRICE_W-1:0] p, output int pos);
        int i;
        pos = lvl_used[b];
        for (i = 0; i < lvl_used[b]; i++) begin
            if (lvl_price[b][i] == p) begin
                pos = i;
                return i;
            end
            if (pos == lvl_used[b] && (b ? p > lvl_price[b][i] : p < lvl_price[b][i]))
                pos = i;
        end
        return -1;
    endfunction

    function automatic bit level_room(bit b, logic [PRICE_W-1:0] p);
        int pos;
        return level_find(b, p, pos) >= 0 || lvl_used[b] < BOOK_LEVELS;
    endfunction

    function automatic void level_join(bit b, logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
        int pos, idx, i;
        idx = level_find(b, p, pos);
        if (idx < 0) begin
            for (i = lvl_used[b]; i > pos; i--) begin
                lvl_price[b][i] = lvl_price[b][i-1];
                lvl_total[b][i] = lvl_total[b][i-1];
                lvl_count[b][i] = lvl_count[b][i-1];
            end
            lvl_price[b][pos] = p;
            lvl_total[b][pos] = '0;
            lvl_count[b][pos] = 0;
            lvl_used[b]++;
            idx = pos;
        end
        lvl_total[b][idx] = lvl_total[b][idx] + TOT_W'(q);
        lvl_count[b][idx]++;
    endfunction

    function automatic void level_leave(bit b, logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
        int pos, idx, i;
        idx = level_find(b, p, pos);
        if (idx < 0) return;
        lvl_total[b][idx] = lvl_total[b][idx] - TOT_W'(q);
        if (lvl_count[b][idx] > 0) lvl_count[b][idx]--;
        if (lvl_count[b][idx] == 0) begin
            for (i = idx; i + 1 < lvl_used[b]; i++) begin
                lvl_price[b][i] = lvl_price[b][i+1];
                lvl_total[b][i] = lvl_total[b][i+1];
                lvl_count[b][i] = lvl_count[b][i+1];
            end
            lvl_used[b]--;
        end
    endfunction

    function automatic void push_result(t_status st, bit lv, bit ls, logic [PRICE_W-1:0] lp,
                                        logic [TOT_W-1:0] lq, bit last);
        t_book_res r;
        r.status = st;
        r.live   = LIVE_OUT_W'(ord_price.num());
        r.nbid   = LVL_OUT_W'(lvl_used[1]);
        r.nask   = LVL_OUT_W'(lvl_used[0]);
        r.lvalid = lv;
        r.lside  = ls;
        r.lprice = lp;
        r.lqty   = lq;
        r.last   = last;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void book_update(t_op op, logic [ID_W-1:0] id, bit buy,
                                        logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q, int depth);
        int nb, na, i, li, pos, qi[$];
        bit b, frees;
        logic [PRICE_W-1:0] oldp;
        logic [QTY_W-1:0] oldq;
        t_status st;
        st = ST_OK;
        if (op == OP_SNAP) begin
            nb = depth < lvl_used[1] ? depth : lvl_used[1];
            na = depth < lvl_used[0] ? depth : lvl_used[0];
            if (nb + na == 0) push_result(ST_OK, 0, 0, '0, '0, 1);
            for (i = 0; i < nb; i++)
                push_result(ST_OK, 1, SIDE_BID, lvl_price[1][i], lvl_total[1][i],
                            i + 1 == nb + na);
            for (i = 0; i < na; i++)
                push_result(ST_OK, 1, SIDE_ASK, lvl_price[0][i], lvl_total[0][i],
                            nb + i + 1 == nb + na);
            return;
        end
        if (op == OP_ADD) begin
            if (ord_price.exists(id)) st = ST_DUP;
            else if (ord_price.num() >= BOOK_ORDERS) st = ST_ORD_FULL;
            else if (!level_room(buy, p)) st = ST_LVL_FULL;
            else begin
                ord_price[id] = p;
                ord_qty[id] = q;
                ord_buy[id] = buy;
                live_ids.insert(live_ids.size(), id);
                level_join(buy, p, q);
            end
        end else if (!ord_price.exists(id)) begin
            st = ST_NOT_FOUND;
        end else begin
            b = ord_buy[id];
            oldp = ord_price[id];
            oldq = ord_qty[id];
            if (op == OP_CANCEL) begin
                level_leave(b, oldp, oldq);
                ord_price.delete(id);
                ord_qty.delete(id);
                ord_buy.delete(id);
                qi = live_ids.find_first_index(x) with (x == id);
                live_ids.delete(qi[0]);
            end else if (p == oldp) begin
                li = level_find(b, oldp, pos);
                if (li >= 0) lvl_total[b][li] = lvl_total[b][li] + TOT_W'(q) - TOT_W'(oldq);
                ord_qty[id] = q;
            end else begin
                li = level_find(b, oldp, pos);
                frees = li >= 0 && lvl_count[b][li] <= 1;
                if (!level_room(b, p) && !frees) st = ST_LVL_FULL;
                else begin
                    level_leave(b, oldp, oldq);
                    ord_price[id] = p;
                    ord_qty[id] = q;
                    level_join(b, p, q);
                end
            end
        end
        push_result(st, 0, 0, '0, '0, 1);
    endfunction

    task automatic send_item(t_op op, logic [ID_W-1:0] id, bit buy, logic [PRICE_W-1:0] p,
                             logic [QTY_W-1:0] q, int depth);
        i_valid          <= 1'b1;
        i_operation      <= op;
        i_order_id       <= id;
        i_is_buy         <= buy;
        i_price          <= p;
        i_quantity       <= q;
        i_snapshot_depth <= DEPTH_W'(depth);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        book_update(op, id, buy, p, q, depth);
        items_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errs++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_book_res e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                errs++;
            end else begin
                e = expected_results.pop_front();
                check_field("status", e.status, o_status);
                check_field("live_orders", e.live, o_live_orders);
                check_field("bid_levels", e.nbid, o_bid_levels);
                check_field("ask_levels", e.nask, o_ask_levels);
                check_field("level_valid", e.lvalid, o_level_valid);
                check_field("level_side", e.lside, o_level_side);
                check_field("level_price", e.lprice, o_level_price);
                check_field("level_quantity", e.lqty, o_level_quantity);
                check_field("last", e.last, o_last);
            end
        end
    end

    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_item(OP_SNAP, '0, 0, '0, '0, 0);
        send_item(OP_SNAP, '0, 1, '0, '0, 16);
        send_item(OP_ADD, '0, 1, '0, '0, 0);
        send_item(OP_ADD, '1, 0, '1, '1, 0);
        send_item(OP_ADD, 64'd5, 1, 32'd100, 32'd7, 0);
        send_item(OP_ADD, 64'd6, 1, 32'd100, 32'd9, 0);
        send_item(OP_ADD, 64'd5, 0, 32'd300, 32'd1, 0);
        send_item(OP_CANCEL, 64'd77, 0, '0, '0, 0);
        send_item(OP_AMEND, 64'd78, 1, 32'd100, 32'd4, 0);
        send_item(OP_AMEND, 64'd5, 0, 32'd100, 32'd20, 0);
        send_item(OP_AMEND, 64'd6, 1, 32'd200, 32'd3, 0);
        send_item(OP_SNAP, '0, 0, '0, '0, 16);
        send_item(OP_SNAP, '0, 0, '0, '0, 1);
        send_item(OP_CANCEL, '0, 0, '0, '0, 0);
        send_item(OP_CANCEL, 64'd5, 0, '0, '0, 0);
        send_item(OP_CANCEL, 64'd6, 0, '0, '0, 0);
        send_item(OP_CANCEL, '1, 1, '0, '0, 0);
        send_item(OP_SNAP, '0, 0, '0, '0, 16);
    endtask

    task automatic test_level_full();
        int i;
        for (i = 0; i < BOOK_LEVELS; i++)
            send_item(OP_ADD, 64'd1000 + i, 0, 32'd500 + 3 * i, 32'd10 + i, 0);
        send_item(OP_ADD, 64'd1100, 0, 32'd503, 32'd4, 0);
        send_item(OP_ADD, 64'd1101, 0, 32'd999, 32'd4, 0);
        send_item(OP_AMEND, 64'd1100, 1, 32'd7, 32'd8, 0);
        send_item(OP_AMEND, 64'd1000, 0, 32'd10000, 32'd6, 0);
        send_item(OP_SNAP, '0, 0, '0, '0, 16);
        while (live_ids.size() != 0)
            send_item(OP_CANCEL, live_ids[0], 0, '0, '0, 0);
    endtask

    task automatic random_item();
        int r;
        logic [ID_W-1:0] id;
        logic [PRICE_W-1:0] p;
        r = $urandom_range(0, 99);
        id = {$urandom, $urandom};
        if (r >= 40 && r < 85 && live_ids.size() != 0 && $urandom_range(0, 9) < 8)
            id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        else if (r < 40 && live_ids.size() != 0 && $urandom_range(0, 19) == 0)
            id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        p = ($urandom_range(0, 9) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 30);
        if (r < 40)
            send_item(OP_ADD, id, $urandom_range(0, 1), p, $urandom, 0);
        else if (r < 60)
            send_item(OP_CANCEL, id, $urandom_range(0, 1), p, $urandom, 0);
        else if (r < 85)
            send_item(OP_AMEND, id, $urandom_range(0, 1),
                      ($urandom_range(0, 2) == 0 && ord_price.exists(id)) ? ord_price[id] : p,
                      $urandom, 0);
        else
            send_item(OP_SNAP, id, $urandom_range(0, 1), p, $urandom,
                      $urandom_range(0, 16));
    endtask

    task automatic test_random(int n);
        int i;
        for (i = 0; i < n; i++) begin
            if (i == n / 3) hold_cycles = 3000;
            if (i == 2 * n / 3) begin
                i_valid <= 1'b0;
                wait_drained();
            end
            random_item();
        end
    endtask

    task automatic test_calm(int n);
        int i;
        calm = 1'b1;
        for (i = 0; i < n; i++) random_item();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_operation      <= OP_ADD;
        i_order_id       <= '0;
        i_is_buy         <= 1'b0;
        i_price          <= '0;
        i_quantity       <= '0;
        i_snapshot_depth <= '0;
        lvl_used[0] = 0;
        lvl_used[1] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_level_full();
        test_random(275);
        test_calm(40);
        i_valid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d items (adds, cancels, amends, snapshots, full-level cases)",
                 items_sent);
        $display("Checked %0d results, %0d mismatches", results_seen, errs);
        if (errs == 0)
            $display("[order_book_level_aggregator_unit] OK");
        else
            $display("[order_book_level_aggregator_unit] ERROR");
        $finish;
    end

    initial begin
        #6000000;
        $display("[order_book_level_aggregator_unit] ERROR");
        $finish;
    end

endmodule
